/* rtl/linear_probe_hash_table_top_macros.svh */
// assertion macros for the hash table checker
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH

`define LPHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define LPHT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lpht_pkg.sv */
package lpht_pkg;
  localparam int unsigned CAPACITY_DEF   = 256;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned HASH_W   = 32;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SCAN_W   = 9;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned LIMIT_W  = 8;
  localparam logic [7:0]  LIMIT_RESET = 8'd192;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_FIND   = 2'd2,
    OP_SCAN   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic [1:0] REG_LOAD_LIMIT = 2'd0;
endpackage

/* rtl/lpht_if.sv */
interface lpht_in_if;
  import lpht_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [HASH_W-1:0]   key_hash;
  logic [KEY_W-1:0]    key;
  logic [VALUE_W-1:0]  value;
  logic [SCAN_W-1:0]   scan_from;
  modport source (output valid, opcode, key_hash, key, value, scan_from, input ready);
  modport sink   (input valid, opcode, key_hash, key, value, scan_from, output ready);
endinterface

interface lpht_out_if;
  import lpht_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [SLOT_W-1:0]   slot_index;
  logic [KEY_W-1:0]    key_out;
  logic [VALUE_W-1:0]  value_out;
  logic [COUNT_W-1:0]  live_count;
  logic [COUNT_W-1:0]  tombstone_count;
  modport source (output valid, status, slot_index, key_out, value_out, live_count,
                  tombstone_count, input ready);
  modport sink   (input valid, status, slot_index, key_out, value_out, live_count,
                  tombstone_count, output ready);
endinterface

/* rtl/linear_probe_hash_table_top.sv */
// channel  | dir | handshake     | payload
// in_      | in  | valid/ready   | opcode, key_hash, key, value, scan_from
// out_     | out | valid/ready   | status, slot_index, key_out, value_out, counts
// cfg_     | in  | apb psel/pen  | load_limit at byte address 0
// an item goes through S_READ and S_EVAL for each probed slot, then S_DONE: one
// synchronous memory read per slot visited, the read port of the slot memory sets
// the pace. worst case walks CAPACITY slots. after reset a clearing pass wipes
// the used/erased marks of every slot while in_ready stays low. a request is taken
// only when the output register is empty or its result leaves at the same edge.
module linear_probe_hash_table_top #(
  parameter int unsigned CAPACITY   = lpht_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lpht_in_if.sink    in_ch,
  lpht_out_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lpht_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL, S_DONE} state_t;

  // one entry: used, erased, key, value
  typedef struct packed {
    logic                  used;
    logic                  erased;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  state_t state_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [1:0]          op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [AW-1:0]       addr_r;
  logic [CW-1:0]       steps_r;
  logic [CW-1:0]       live_r, dead_r;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_data;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [1:0]          out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [VALUE_W-1:0]  out_val_r;
  logic [COUNT_W-1:0]  out_live_r, out_dead_r;

  logic cfg_wr;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_LOAD_LIMIT) ? {24'd0, limit_r} : 32'd0;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.slot_index      = out_slot_r;
  assign out_ch.key_out         = out_key_r;
  assign out_ch.value_out       = out_val_r;
  assign out_ch.live_count      = out_live_r;
  assign out_ch.tombstone_count = out_dead_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) out_valid_nxt = 1'b1;
  end

  logic        hit, stop, last;
  always_comb begin
    hit  = 1'b0;
    stop = 1'b0;
    last = (steps_r == CW'(CAPACITY - 1));
    case (op_r)
      OP_INSERT: hit = !rd_data_r.used;
      OP_ERASE, OP_FIND: begin
        hit  = rd_data_r.used && !rd_data_r.erased && rd_data_r.key == key_r;
        stop = !rd_data_r.used;
      end
      OP_SCAN: begin
        hit  = rd_data_r.used && !rd_data_r.erased;
        last = (addr_r == AW'(CAPACITY - 1));
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = rd_data_r;
    if (state_r == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_data = '0;
    end else if (state_r == S_EVAL && hit) begin
      if (op_r == OP_INSERT) begin
        wr_en   = 1'b1;
        wr_data = '{used: 1'b1, erased: 1'b0, key: key_r, value: val_r};
      end else if (op_r == OP_ERASE) begin
        wr_en          = 1'b1;
        wr_data.erased = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[addr_r];
  end

  logic [KEY_W-1:0]   key_ext;
  logic [VALUE_W-1:0] val_ext;
  assign key_ext = KEY_W'(rd_data_r.key);
  assign val_ext = VALUE_W'(rd_data_r.value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      limit_r     <= LIMIT_RESET;
      live_r      <= '0;
      dead_r      <= '0;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
    end else begin
      if (cfg_wr && cfg_paddr == REG_LOAD_LIMIT) limit_r <= cfg_pwdata[LIMIT_W-1:0];
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_CLEAR: begin
          addr_r <= addr_r + AW'(1);
          if (addr_r == AW'(CAPACITY - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            op_r    <= in_ch.opcode;
            key_r   <= in_ch.key[KEY_BITS-1:0];
            val_r   <= in_ch.value[VALUE_BITS-1:0];
            steps_r <= '0;
            out_key_r    <= '0;
            out_val_r    <= '0;
            out_slot_r   <= '0;
            out_status_r <= ST_MISS;
            if (op_t'(in_ch.opcode) == OP_SCAN) begin
              addr_r  <= in_ch.scan_from[AW-1:0];
              state_r <= (32'(in_ch.scan_from) >= CAPACITY) ? S_DONE : S_READ;
            end else begin
              addr_r <= in_ch.key_hash[AW-1:0];
              if (op_t'(in_ch.opcode) == OP_INSERT &&
                  32'(live_r) + 32'(dead_r) >= 32'(limit_r)) begin
                out_status_r <= ST_FULL;
                state_r      <= S_DONE;
              end else begin
                state_r <= S_READ;
              end
            end
          end
        end
        S_READ: state_r <= S_EVAL;
        S_EVAL: begin
          if (hit) begin
            out_status_r <= ST_OK;
            out_slot_r   <= SLOT_W'(addr_r);
            if (op_r == OP_INSERT) live_r <= live_r + CW'(1);
            if (op_r == OP_ERASE) begin
              if (live_r != '0) live_r <= live_r - CW'(1);
              dead_r <= dead_r + CW'(1);
            end
            if (op_r == OP_FIND || op_r == OP_SCAN) begin
              out_key_r <= key_ext;
              out_val_r <= val_ext;
            end
            state_r <= S_DONE;
          end else if (stop || last) begin
            if (op_r == OP_INSERT) out_status_r <= ST_FULL;
            state_r <= S_DONE;
          end else begin
            addr_r  <= addr_r + AW'(1);
            steps_r <= steps_r + CW'(1);
            state_r <= S_READ;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_live_r  <= COUNT_W'(live_r);
            out_dead_r  <= COUNT_W'(dead_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/lpht_checker.sv */
module lpht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [7:0]  out_slot_index,
  input logic [31:0] out_key_out
);
  import lpht_pkg::*;
  `include "linear_probe_hash_table_top_macros.svh"

  `LPHT_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `LPHT_ASSERT_IMP(a_status, clk, rst_n, out_valid, out_status <= ST_FULL, "bad status")
  `LPHT_ASSERT_IMP(a_miss, clk, rst_n, out_valid && out_status != ST_OK, out_slot_index == 8'd0 && out_key_out == 32'd0, "miss carries data")
  `LPHT_ASSERT_NXT(a_one, clk, rst_n, in_valid && in_ready, !in_ready, "second request taken")
endmodule

bind linear_probe_hash_table_top lpht_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_slot_index(out_ch.slot_index),
  .out_key_out(out_ch.key_out)
);

/* sim/linear_probe_hash_table_top_tb.sv */
`timescale 1ns / 1ps

module linear_probe_hash_table_top_tb;
  import lpht_pkg::*;

  localparam int NSLOT = 256;
  localparam int CYCLE_LIMIT = 5000000;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot_index;
    logic [KEY_W-1:0]   key_out;
    logic [VALUE_W-1:0] value_out;
    logic [COUNT_W-1:0] live_count;
    logic [COUNT_W-1:0] tombstone_count;
  } table_result_t;

  class table_scoreboard;
    logic [KEY_W-1:0]   keys [NSLOT];
    logic [VALUE_W-1:0] vals [NSLOT];
    bit                 used [NSLOT];
    bit                 erased [NSLOT];
    int unsigned        live_n;
    int unsigned        dead_n;
    int unsigned        limit;
    table_result_t      pending[$];
    int                 errors;

    function void clear();
      for (int i = 0; i < NSLOT; i++) begin
        used[i] = 0;
        erased[i] = 0;
      end
      live_n = 0;
      dead_n = 0;
      limit = LIMIT_RESET;
      errors = 0;
    endfunction

    function int find_live(int home, logic [KEY_W-1:0] k);
      int s;
      s = home;
      for (int n = 0; n < NSLOT && used[s]; n++) begin
        if (!erased[s] && keys[s] == k) return s;
        s = (s + 1) % NSLOT;
      end
      return -1;
    endfunction

    function void note_request(op_t op, logic [31:0] kh, logic [31:0] k, logic [31:0] v,
                               logic [8:0] from);
      table_result_t r;
      int home, s, hit;
      home = int'(kh % NSLOT);
      r = '0;
      r.status = ST_MISS;
      case (op)
        OP_INSERT: begin
          r.status = ST_FULL;
          if (live_n + dead_n < limit) begin
            s = home;
            for (int n = 0; n < NSLOT; n++) begin
              if (!used[s]) begin
                keys[s] = k;
                vals[s] = v;
                used[s] = 1;
                erased[s] = 0;
                live_n++;
                r.status = ST_OK;
                r.slot_index = SLOT_W'(s);
                break;
              end
              s = (s + 1) % NSLOT;
            end
          end
        end
        OP_ERASE: begin
          hit = find_live(home, k);
          if (hit >= 0) begin
            erased[hit] = 1;
            if (live_n > 0) live_n--;
            dead_n++;
            r.status = ST_OK;
            r.slot_index = SLOT_W'(hit);
          end
        end
        OP_FIND: begin
          hit = find_live(home, k);
          if (hit >= 0) begin
            r.status = ST_OK;
            r.slot_index = SLOT_W'(hit);
            r.key_out = keys[hit];
            r.value_out = vals[hit];
          end
        end
        default: begin
          for (int i = from; i < NSLOT; i++) begin
            if (used[i] && !erased[i]) begin
              r.status = ST_OK;
              r.slot_index = SLOT_W'(i);
              r.key_out = keys[i];
              r.value_out = vals[i];
              break;
            end
          end
        end
      endcase
      r.live_count = COUNT_W'(live_n);
      r.tombstone_count = COUNT_W'(dead_n);
      pending.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) report("status", exp.status, got.status);
      if (got.slot_index !== exp.slot_index) report("slot_index", exp.slot_index, got.slot_index);
      if (got.key_out !== exp.key_out) report("key_out", exp.key_out, got.key_out);
      if (got.value_out !== exp.value_out) report("value_out", exp.value_out, got.value_out);
      if (got.live_count !== exp.live_count)
        report("live_count", exp.live_count, got.live_count);
      if (got.tombstone_count !== exp.tombstone_count)
        report("tombstone_count", exp.tombstone_count, got.tombstone_count);
    endfunction

    function void report(string field, logic [31:0] exp, logic [31:0] act);
      $display("%0t: %s expected %0h actual %0h", $time, field, exp, act);
      errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  lpht_in_if in_ch ();
  lpht_out_if out_ch ();

  linear_probe_hash_table_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  table_scoreboard sb;
  bit calm;
  int cycles = 0;
  logic [31:0] key_pool [16];

  initial begin
    in_ch.valid = 0;
    in_ch.opcode = '0;
    in_ch.key_hash = '0;
    in_ch.key = '0;
    in_ch.value = '0;
    in_ch.scan_from = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({status_t'(out_ch.status), out_ch.slot_index, out_ch.key_out,
                       out_ch.value_out, out_ch.live_count, out_ch.tombstone_count});
  end

  initial begin
    int gap;
    gap = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (calm) out_ch.ready <= 1;
      else if (gap > 0) begin
        out_ch.ready <= 0;
        gap--;
      end else begin
        out_ch.ready <= 1;
        if ($urandom_range(0, 5) == 0) gap = $urandom_range(1, 5);
      end
    end
  end

  task automatic write_limit(logic [7:0] lim);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= REG_LOAD_LIMIT;
    cfg_pwdata <= lim;
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.limit = lim;
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  task automatic send(op_t op, logic [31:0] kh, logic [31:0] k, logic [31:0] v,
                      logic [8:0] from);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.key_hash <= kh;
    in_ch.key <= k;
    in_ch.value <= v;
    in_ch.scan_from <= from;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(op, kh, k, v, from);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic random_phase(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send(OP_INSERT, $urandom_range(0, 40) + (pick << 8) * $urandom_range(0, 1),
                         key_pool[pick], $urandom, 9'd0);
        4, 5: send(OP_ERASE, pick * $urandom_range(0, 3), key_pool[pick], $urandom, 9'd0);
        6, 7: send(OP_FIND, $urandom_range(0, 40), key_pool[pick], $urandom, 9'($urandom));
        8: send(OP_SCAN, $urandom, $urandom, $urandom, 9'($urandom_range(0, 300)));
        default: send(op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                      9'($urandom));
      endcase
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    calm = 0;
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hffff_ffff;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: empty table misses, extremes, collisions, tombstones, scans
    send(OP_FIND, 32'h0, 32'h0, 32'h0, 9'd0);
    send(OP_ERASE, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 9'd0);
    send(OP_SCAN, 32'h0, 32'h0, 32'h0, 9'd0);
    send(OP_INSERT, 32'h0, 32'h0, 32'hffff_ffff, 9'd0);
    send(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 9'd0);
    send(OP_INSERT, 32'h0000_0100, 32'h1234_5678, 32'h5555_aaaa, 9'd0);
    send(OP_INSERT, 32'h0, 32'h1234_5678, 32'haaaa_5555, 9'd0);
    send(OP_INSERT, 32'h0000_00ff, 32'hdead_beef, 32'h1, 9'd0);
    send(OP_FIND, 32'h0000_0100, 32'h1234_5678, 32'h0, 9'd0);
    send(OP_ERASE, 32'h0, 32'h1234_5678, 32'h0, 9'd0);
    send(OP_FIND, 32'h0, 32'h1234_5678, 32'h0, 9'd0);
    send(OP_INSERT, 32'h1, 32'h7777_7777, 32'h2, 9'd0);
    send(OP_SCAN, 32'h0, 32'h0, 32'h0, 9'd1);
    send(OP_SCAN, 32'h0, 32'h0, 32'h0, 9'd255);
    send(OP_SCAN, 32'h0, 32'h0, 32'h0, 9'd256);
    send(OP_SCAN, 32'h0, 32'h0, 32'h0, 9'h1ff);
    send(OP_FIND, 32'h0000_00ff, 32'h0, 32'h0, 9'd0);
    drain();

    // tiny limit: refusals at the load limit
    write_limit(8'd1);
    send(OP_INSERT, 32'h5, 32'h5, 32'h5, 9'd0);
    drain();
    write_limit(8'd40);
    random_phase(300);
    drain();
    write_limit(8'd255);
    random_phase(500);
    // hold until all results are in
    drain();
    write_limit(8'd100);
    random_phase(400);
    drain();
    write_limit(LIMIT_RESET);
    random_phase(500);
    drain();
    calm = 1;
    random_phase(200);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_if.sv
rtl/linear_probe_hash_table_top.sv
rtl/lpht_checker.sv
sim/linear_probe_hash_table_top_tb.sv
